// ===== src/jfs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_pkg
// Shared types and constants of the JPEG frame size scanner.
// ----------------------------------------------------------------------------
package jfs_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned DimW  = 16;
  localparam int unsigned WinW  = 16;
  localparam int unsigned PosW  = 20;

  localparam logic [WinW-1:0] ScanWindowRst = 16'd4096;
  localparam logic [PosW-1:0] PosMax        = 20'hF_FFFF;

  // Marker codes
  localparam logic [DataW-1:0] MrkPrefix = 8'hFF;
  localparam logic [DataW-1:0] MrkStuff  = 8'h00;
  localparam logic [DataW-1:0] MrkSof0   = 8'hC0;
  localparam logic [DataW-1:0] MrkSof1   = 8'hC1;
  localparam logic [DataW-1:0] MrkSof2   = 8'hC2;
  localparam logic [DataW-1:0] MrkRstLo  = 8'hD0;
  localparam logic [DataW-1:0] MrkEoi    = 8'hD9;

  typedef struct packed {
    logic            found;
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
  } jfs_result_t;

endpackage

// ===== src/jfs_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_parser
// Per-byte marker parser: one state update for every accepted byte, with a
// result pushed out on the beat that completes it.
// ----------------------------------------------------------------------------
module jfs_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [jfs_pkg::WinW-1:0]       cfg_wr_data,
  input  logic                           acc,
  input  logic [jfs_pkg::DataW-1:0]      data_byte,
  input  logic                           last_byte,
  output logic                           res_push,
  output jfs_pkg::jfs_result_t           res_data
);
  import jfs_pkg::*;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_MARKER,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIP,
    PH_SOF,
    PH_DONE
  } phase_t;

  logic [WinW-1:0]  scan_window_r;
  phase_t           phase_r, phase_nxt;
  logic [PosW-1:0]  pos_r, pos_nxt;
  logic [DimW-1:0]  skip_r, skip_nxt;
  logic [DataW-1:0] len_hi_r, len_hi_nxt;
  logic [2:0]       sof_idx_r, sof_idx_nxt;
  logic [DimW-1:0]  height_r, height_nxt;
  logic             given_r, given_nxt;

  logic             emit;
  jfs_result_t      res;
  logic [PosW:0]    cur_e, win_e, cur_p1, cur_p2, seg_end;
  logic [DimW-1:0]  seg_len, seg_len_m1;

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    skip_nxt    = skip_r;
    len_hi_nxt  = len_hi_r;
    sof_idx_nxt = sof_idx_r;
    height_nxt  = height_r;
    given_nxt   = given_r;
    emit        = 1'b0;
    res         = '0;

    cur_e  = {1'b0, pos_r};
    win_e  = {{(PosW + 1 - WinW){1'b0}}, scan_window_r};
    cur_p1 = cur_e + 21'd1;
    cur_p2 = cur_e + 21'd2;

    seg_len = {len_hi_r, data_byte};
    if (seg_len < 16'd2) begin
      seg_len = 16'd2;
    end
    seg_len_m1 = seg_len - 16'd1;
    seg_end    = cur_e + {{(PosW + 1 - DimW){1'b0}}, seg_len_m1};

    if (phase_r != PH_DONE && pos_r != PosMax) begin
      pos_nxt = pos_r + 20'd1;
    end

    case (phase_r)
      PH_SEARCH: begin
        if (cur_e >= win_e) begin
          emit = 1'b1;
        end else if (data_byte == MrkPrefix) begin
          phase_nxt = PH_MARKER;
        end else if (cur_p1 >= win_e) begin
          emit = 1'b1;
        end
      end
      PH_MARKER: begin
        if (data_byte == MrkSof0 || data_byte == MrkSof1 || data_byte == MrkSof2) begin
          phase_nxt   = PH_SOF;
          sof_idx_nxt = 3'd0;
        end else if (data_byte == MrkPrefix) begin
          // fill byte: stay on the marker, the byte may open the next one
          if (cur_e >= win_e) begin
            emit = 1'b1;
          end
        end else if (data_byte == MrkStuff ||
                     (data_byte >= MrkRstLo && data_byte <= MrkEoi) ||
                     cur_p2 >= win_e) begin
          if (cur_p1 >= win_e) begin
            emit = 1'b1;
          end else begin
            phase_nxt = PH_SEARCH;
          end
        end else begin
          phase_nxt = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_hi_nxt = data_byte;
        phase_nxt  = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        if (seg_end >= win_e) begin
          emit = 1'b1;
        end else if (seg_len == 16'd2) begin
          phase_nxt = PH_SEARCH;
        end else begin
          skip_nxt  = seg_len - 16'd2;
          phase_nxt = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (skip_r != '0) begin
          skip_nxt = skip_r - 16'd1;
        end
        if (skip_r <= 16'd1) begin
          phase_nxt = PH_SEARCH;
        end
      end
      PH_SOF: begin
        if (sof_idx_r == 3'd3) begin
          height_nxt = {data_byte, 8'h00};
        end else if (sof_idx_r == 3'd4) begin
          height_nxt = {height_r[15:8], data_byte};
        end else if (sof_idx_r == 3'd5) begin
          len_hi_nxt = data_byte;
        end else if (sof_idx_r >= 3'd6) begin
          emit         = 1'b1;
          res.found    = 1'b1;
          res.width    = {len_hi_r, data_byte};
          res.height   = height_r;
        end
        if (sof_idx_r != 3'd7) begin
          sof_idx_nxt = sof_idx_r + 3'd1;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (emit) begin
      phase_nxt = PH_DONE;
      given_nxt = 1'b1;
    end

    // end of image: report a miss if nothing went out, then rearm
    if (last_byte) begin
      if (!emit && !given_r) begin
        emit = 1'b1;
        res  = '0;
      end
      phase_nxt   = PH_SEARCH;
      pos_nxt     = '0;
      skip_nxt    = '0;
      len_hi_nxt  = '0;
      sof_idx_nxt = '0;
      height_nxt  = '0;
      given_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_window_r <= ScanWindowRst;
      phase_r       <= PH_SEARCH;
      pos_r         <= '0;
      skip_r        <= '0;
      len_hi_r      <= '0;
      sof_idx_r     <= '0;
      height_r      <= '0;
      given_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        scan_window_r <= cfg_wr_data;
      end
      if (acc) begin
        phase_r   <= phase_nxt;
        pos_r     <= pos_nxt;
        skip_r    <= skip_nxt;
        len_hi_r  <= len_hi_nxt;
        sof_idx_r <= sof_idx_nxt;
        height_r  <= height_nxt;
        given_r   <= given_nxt;
      end
    end
  end

  assign res_push = acc & emit;
  assign res_data = res;

endmodule

// ===== src/jfs_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_out_buf
// Result register with one skid entry behind it, so the parser keeps
// taking bytes while a result waits on a stalled receiver.
// ----------------------------------------------------------------------------
module jfs_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  jfs_pkg::jfs_result_t push_data,
  input  logic                 out_stall,
  output logic                 out_valid,
  output jfs_pkg::jfs_result_t out_data,
  output logic                 full
);
  import jfs_pkg::*;

  logic        main_v_r, main_v_nxt;
  logic        skid_v_r, skid_v_nxt;
  jfs_result_t main_r, main_nxt;
  jfs_result_t skid_r, skid_nxt;
  logic        pop;

  assign pop = main_v_r & ~out_stall;

  always_comb begin
    main_v_nxt = main_v_r;
    main_nxt   = main_r;
    skid_v_nxt = skid_v_r;
    skid_nxt   = skid_r;
    if (!main_v_r || pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        main_v_nxt = 1'b1;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end else begin
        main_v_nxt = 1'b0;
      end
    end else if (push) begin
      // main beat stalled: park the new result
      skid_nxt   = push_data;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = main_v_r;
  assign out_data  = main_r;
  assign full      = skid_v_r;

endmodule

// ===== src/jpeg_frame_size_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jpeg_frame_size_scanner
// Finds the first SOF0/SOF1/SOF2 marker in a JPEG byte stream and reports
// the frame height and width, or a miss.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one stream byte per beat, in_last_byte on the final
//   byte of each image. Output channel (out_*): at most one result per image,
//   found=0 with zero dimensions when no SOF starts inside the scan window.
//   cfg_wr_en/cfg_wr_data load the 16-bit scan window (reset 4096); write it
//   only while no image is in flight.
//   Throughput: one byte per cycle while in_stall is low; the marker parser
//   updates its state once for every accepted byte. A result is registered in
//   the output buffer and shown on out_* from there.
//   Stall: results queue in a two-entry output buffer (result register plus
//   skid entry); in_stall rises only while both entries hold results.
//   Reset (rst_n low, synchronous): parser rearmed, window back to 4096,
//   output buffer emptied.
// ----------------------------------------------------------------------------
module jpeg_frame_size_scanner (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [jfs_pkg::WinW-1:0]   cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [jfs_pkg::DataW-1:0]  in_data_byte,
  input  logic                       in_last_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_found,
  output logic [jfs_pkg::DimW-1:0]   out_image_width,
  output logic [jfs_pkg::DimW-1:0]   out_image_height
);
  import jfs_pkg::*;

  logic        acc;
  logic        res_push;
  logic        buf_full;
  jfs_result_t res_data;
  jfs_result_t out_data;

  assign in_stall = buf_full;
  assign acc      = in_valid & ~buf_full;

  jfs_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .acc        (acc),
    .data_byte  (in_data_byte),
    .last_byte  (in_last_byte),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  jfs_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_data),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .full     (buf_full)
  );

  assign out_found        = out_data.found;
  assign out_image_width  = out_data.width;
  assign out_image_height = out_data.height;

endmodule

// ===== src/jfs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jfs_checker
// Port-level checks of the frame size scanner, bound to the top level.
// ----------------------------------------------------------------------------
module jfs_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_found,
  input logic [jfs_pkg::DimW-1:0]   out_image_width,
  input logic [jfs_pkg::DimW-1:0]   out_image_height
);

  // reset empties the output buffer
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // input backs up only while a result is held
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // a miss carries zero dimensions
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_image_width == '0 && out_image_height == '0)
    else $error("miss reported with nonzero size");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_found) && $stable(out_image_width) &&
      $stable(out_image_height))
    else $error("stalled result changed");

endmodule

bind jpeg_frame_size_scanner jfs_checker u_jfs_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_found       (out_found),
  .out_image_width (out_image_width),
  .out_image_height(out_image_height)
);
